### rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and precedence helpers for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam logic [7:0] CH_POW   = 8'h5E;  // '^'
   localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
   localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
   localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
   localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
   localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
   localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'

   localparam logic [1:0] FLT_NONE     = 2'd0;
   localparam logic [1:0] FLT_OVERFLOW = 2'd1;
   localparam logic [1:0] FLT_CLOSE    = 2'd2;

   typedef enum logic [1:0] {
      STK_NONE,
      STK_PUSH,
      STK_POP,
      STK_PEEK
   } stk_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stk_stat_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_present;
      logic       last_of_expr;
      logic [1:0] fault;
   } rsp_word_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_CLASS,
      SQ_PEEK,
      SQ_PUSH,
      SQ_FLUSH,
      SQ_FPEEK,
      SQ_FIN
   } seq_state_type;

   // precedence biased by one: other bytes (and '(') rank 0
   function automatic logic [2:0] rank_of(input logic [7:0] ch);
      logic [2:0] r;
      r = 3'd0;
      case (ch)
         CH_POW:         r = 3'd4;
         CH_MUL, CH_DIV: r = 3'd3;
         CH_ADD, CH_SUB: r = 3'd2;
         default:        r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_letter(input logic [7:0] ch);
      return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
   endfunction

endpackage

### rtl/core/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack: single-port memory with fill count and registered top read.
// ----------------------------------------------------------------------------
module itp_stack
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  stk_cmd_type  cmd,
   input  logic [7:0]   wr_data,
   output logic [7:0]   top_data,
   output stk_stat_type stat
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [7:0]    mem [STACK_DEPTH];
   logic [7:0]    rd_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_m1;

   assign count_m1 = count_ff - CW'(1);

   always_comb begin
      count_in = count_ff;
      unique case (cmd)
         STK_PUSH: count_in = count_ff + CW'(1);
         STK_POP:  count_in = count_m1;
         STK_NONE,
         STK_PEEK: count_in = count_ff;
         default:  count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == STK_PUSH) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      if (cmd == STK_PEEK) begin
         rd_ff <= mem[count_m1[AW-1:0]];
      end
   end

   assign top_data   = rd_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(STACK_DEPTH));

endmodule

### rtl/core/itp_rsp_reg.sv
// ----------------------------------------------------------------------------
// itp_rsp_reg
// Result output register with valid/stall handshake.
// ----------------------------------------------------------------------------
module itp_rsp_reg
   import itp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type word,
   output logic         slot_free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_char,
   output logic         rsp_char_present,
   output logic         rsp_last_of_expr,
   output logic [1:0]   rsp_fault
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = slot_free ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && slot_free) begin
         word_ff <= word;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_char     = word_ff.out_char;
   assign rsp_char_present = word_ff.char_present;
   assign rsp_last_of_expr = word_ff.last_of_expr;
   assign rsp_fault        = word_ff.fault;

endmodule

### rtl/core/itp_seq.sv
// ----------------------------------------------------------------------------
// itp_seq
// Sequencer: classifies each input byte, drives stack push/pop/peek through
// one precedence compare, and holds one result back so the final word of an
// expression can carry its last flag.
// ----------------------------------------------------------------------------
module itp_seq
   import itp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_in_char,
   input  logic         req_end_of_expr,
   output stk_cmd_type  stk_cmd,
   output logic [7:0]   stk_wr_data,
   input  logic [7:0]   stk_top,
   input  stk_stat_type stk_stat,
   input  logic         slot_free,
   output logic         out_load,
   output rsp_word_type out_word
);

   seq_state_type state_ff;
   seq_state_type state_in;
   logic [7:0]    ch_ff;
   logic          last_ff;
   rsp_word_type  pend_ff;
   logic          pend_v_ff;

   logic          emit_ok;
   logic          do_emit;
   rsp_word_type  new_word;
   logic          fin_load;
   rsp_word_type  fin_word;
   logic          ch_letter;
   logic          pop_ok;
   logic          accept;

   assign emit_ok   = !pend_v_ff || slot_free;
   assign ch_letter = is_letter(ch_ff);
   assign pop_ok    = (rank_of(stk_top) >= rank_of(ch_ff));
   assign accept    = (state_ff == SQ_IDLE) && req_valid;
   assign req_stall = (state_ff != SQ_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (req_valid) state_in = SQ_CLASS;
         end
         SQ_CLASS: begin
            if (ch_letter) begin
               state_in = emit_ok ? SQ_FLUSH : SQ_CLASS;
            end else if (ch_ff == CH_OPEN) begin
               state_in = SQ_PUSH;
            end else if (stk_stat.empty) begin
               if (ch_ff == CH_CLOSE) state_in = emit_ok ? SQ_FLUSH : SQ_CLASS;
               else                   state_in = SQ_PUSH;
            end else begin
               state_in = SQ_PEEK;
            end
         end
         SQ_PEEK: begin
            if (ch_ff == CH_CLOSE) begin
               if (stk_top == CH_OPEN) state_in = SQ_FLUSH;
               else                    state_in = emit_ok ? SQ_CLASS : SQ_PEEK;
            end else if (pop_ok) begin
               state_in = emit_ok ? SQ_CLASS : SQ_PEEK;
            end else begin
               state_in = SQ_PUSH;
            end
         end
         SQ_PUSH: begin
            if (!stk_stat.full) state_in = SQ_FLUSH;
            else                state_in = emit_ok ? SQ_FLUSH : SQ_PUSH;
         end
         SQ_FLUSH: begin
            state_in = (last_ff && !stk_stat.empty) ? SQ_FPEEK : SQ_FIN;
         end
         SQ_FPEEK: begin
            state_in = emit_ok ? SQ_FLUSH : SQ_FPEEK;
         end
         SQ_FIN: begin
            if (pend_v_ff || last_ff) state_in = slot_free ? SQ_IDLE : SQ_FIN;
            else                      state_in = SQ_IDLE;
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      do_emit  = 1'b0;
      new_word = '0;
      stk_cmd  = STK_NONE;
      fin_load = 1'b0;
      fin_word = '0;
      unique case (state_ff)
         SQ_IDLE: ;
         SQ_CLASS: begin
            if (ch_letter) begin
               do_emit               = emit_ok;
               new_word.out_char     = ch_ff;
               new_word.char_present = 1'b1;
            end else if (ch_ff == CH_OPEN) begin
               stk_cmd = STK_NONE;
            end else if (stk_stat.empty) begin
               if (ch_ff == CH_CLOSE) begin
                  do_emit        = emit_ok;
                  new_word.fault = FLT_CLOSE;
               end
            end else begin
               stk_cmd = STK_PEEK;
            end
         end
         SQ_PEEK: begin
            if (ch_ff == CH_CLOSE && stk_top == CH_OPEN) begin
               stk_cmd = STK_POP;
            end else if (ch_ff == CH_CLOSE || pop_ok) begin
               new_word.out_char     = stk_top;
               new_word.char_present = 1'b1;
               if (emit_ok) begin
                  do_emit = 1'b1;
                  stk_cmd = STK_POP;
               end
            end
         end
         SQ_PUSH: begin
            if (!stk_stat.full) begin
               stk_cmd = STK_PUSH;
            end else begin
               do_emit        = emit_ok;
               new_word.fault = FLT_OVERFLOW;
            end
         end
         SQ_FLUSH: begin
            if (last_ff && !stk_stat.empty) stk_cmd = STK_PEEK;
         end
         SQ_FPEEK: begin
            new_word.out_char     = stk_top;
            new_word.char_present = 1'b1;
            if (emit_ok) begin
               do_emit = 1'b1;
               stk_cmd = STK_POP;
            end
         end
         SQ_FIN: begin
            if (pend_v_ff) begin
               fin_load              = slot_free;
               fin_word              = pend_ff;
               fin_word.last_of_expr = last_ff;
            end else if (last_ff) begin
               fin_load              = slot_free;
               fin_word.last_of_expr = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign stk_wr_data = ch_ff;
   assign out_load    = (do_emit && pend_v_ff) || fin_load;
   assign out_word    = do_emit ? pend_ff : fin_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SQ_IDLE;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_emit) begin
            pend_v_ff <= 1'b1;
         end else if (fin_load) begin
            pend_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff   <= req_in_char;
         last_ff <= req_end_of_expr;
      end
      if (do_emit) begin
         pend_ff <= new_word;
      end
   end

endmodule

### rtl/core/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix to postfix converter, one byte per input word.
// ----------------------------------------------------------------------------
// Takes an infix expression one byte per word (end_of_expr on the final
// byte) and returns the postfix bytes, plus marker words for stack overflow,
// an unmatched ')' and an expression that yields nothing. One byte at a time
// is in work; req_stall stays high until all its words are handed to the
// output register. A letter passes accept, classify, flush check and
// release. Every look at the stack top waits for the registered memory read:
// each entry popped by an operator or ')' takes a read, then a pop and a new
// classify, and the compare that stops an operator's pops, or finds the '('
// for a ')', takes one more read. A push or an overflow marker adds a step,
// and the end-of-expression flush reads and pops each stacked entry. The
// stack memory's single registered read port sets the read-then-pop step.
// Result words are held back one slot so the last one can be flagged; stalls
// on rsp_stall lengthen these steps.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_present,
   output logic       rsp_last_of_expr,
   output logic [1:0] rsp_fault
);

   stk_cmd_type  stk_cmd;
   logic [7:0]   stk_wr_data;
   logic [7:0]   stk_top;
   stk_stat_type stk_stat;
   logic         slot_free;
   logic         out_load;
   rsp_word_type out_word;

   itp_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_end_of_expr (req_end_of_expr),
      .stk_cmd         (stk_cmd),
      .stk_wr_data     (stk_wr_data),
      .stk_top         (stk_top),
      .stk_stat        (stk_stat),
      .slot_free       (slot_free),
      .out_load        (out_load),
      .out_word        (out_word)
   );

   itp_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .cmd      (stk_cmd),
      .wr_data  (stk_wr_data),
      .top_data (stk_top),
      .stat     (stk_stat)
   );

   itp_rsp_reg u_rsp (
      .clock            (clock),
      .reset            (reset),
      .load             (out_load),
      .word             (out_word),
      .slot_free        (slot_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_present (rsp_char_present),
      .rsp_last_of_expr (rsp_last_of_expr),
      .rsp_fault        (rsp_fault)
   );

endmodule

### tb/infix_to_postfix_converter_unit_test.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_test
// Self-checking bench for the shunting-yard infix to postfix converter.
// ----------------------------------------------------------------------------
// Feeds directed expressions (deepest stack, overflow, stray ')', empty end,
// every operator and the byte extremes), then random expressions that are
// mostly well formed, some deeply nested, some with corrupted bytes. A local
// stack model predicts each result word; words are checked in order at the
// rising edge. Both sides idle at random, and the receiver holds off once
// for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module infix_to_postfix_converter_unit_test;
   import itp_pkg::*;

   localparam int OP_STACK_DEPTH = 16;
   localparam int RANDOM_ITEMS   = 400;
   localparam int STUCK_LIMIT    = 3000;
   localparam int HOLD_CYCLES    = 300;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } infix_byte_type;

   typedef logic [7:0] byte_q_type[$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char = 8'h00;
   logic       req_end_of_expr = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_char_present;
   logic       rsp_last_of_expr;
   logic [1:0] rsp_fault;

   infix_byte_type infix_pending[$];
   rsp_word_type   postfix_due[$];
   logic [7:0]     op_stack_m [OP_STACK_DEPTH];
   int             op_depth = 0;

   logic           req_fired = 1'b0;
   infix_byte_type next_byte;
   int             bytes_taken = 0;
   int             words_taken = 0;
   int             mismatches = 0;
   int             stuck_cycles = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;

   infix_to_postfix_converter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_char      (req_in_char),
      .req_end_of_expr  (req_end_of_expr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_present (rsp_char_present),
      .rsp_last_of_expr (rsp_last_of_expr),
      .rsp_fault        (rsp_fault)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int precedence(input logic [7:0] ch);
      case (ch)
         CH_POW:         return 3;
         CH_MUL, CH_DIV: return 2;
         CH_ADD, CH_SUB: return 1;
         default:        return -1;
      endcase
   endfunction

   function automatic rsp_word_type make_word(input logic [7:0] ch, input logic present,
                                              input logic [1:0] flt);
      rsp_word_type w;
      w.out_char     = present ? ch : 8'h00;
      w.char_present = present;
      w.last_of_expr = 1'b0;
      w.fault        = flt;
      return w;
   endfunction

   // expected postfix words for one accepted infix byte
   task automatic convert_infix_byte(input logic [7:0] ch, input logic fin);
      rsp_word_type words[$];
      rsp_word_type w;
      int           rank_in;
      bit           do_push;
      do_push = 1'b0;
      if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A)) begin
         words.push_back(make_word(ch, 1'b1, FLT_NONE));
      end else if (ch == CH_OPEN) begin
         do_push = 1'b1;
      end else if (ch == CH_CLOSE) begin
         while (op_depth > 0 && op_stack_m[op_depth-1] != CH_OPEN) begin
            op_depth--;
            words.push_back(make_word(op_stack_m[op_depth], 1'b1, FLT_NONE));
         end
         if (op_depth > 0)
            op_depth--;
         else
            words.push_back(make_word(8'h00, 1'b0, FLT_CLOSE));
      end else begin
         rank_in = precedence(ch);
         while (op_depth > 0 && precedence(op_stack_m[op_depth-1]) >= rank_in) begin
            op_depth--;
            words.push_back(make_word(op_stack_m[op_depth], 1'b1, FLT_NONE));
         end
         do_push = 1'b1;
      end
      if (do_push) begin
         if (op_depth < OP_STACK_DEPTH) begin
            op_stack_m[op_depth] = ch;
            op_depth++;
         end else begin
            words.push_back(make_word(8'h00, 1'b0, FLT_OVERFLOW));
         end
      end
      if (fin) begin
         while (op_depth > 0) begin
            op_depth--;
            words.push_back(make_word(op_stack_m[op_depth], 1'b1, FLT_NONE));
         end
         if (words.size() == 0)
            words.push_back(make_word(8'h00, 1'b0, FLT_NONE));
      end
      foreach (words[i]) begin
         w = words[i];
         w.last_of_expr = fin && (i == words.size() - 1);
         postfix_due.push_back(w);
      end
   endtask

   task automatic queue_expr(input byte_q_type text);
      infix_byte_type b;
      foreach (text[i]) begin
         b.ch  = text[i];
         b.fin = (i == text.size() - 1);
         infix_pending.push_back(b);
      end
   endtask

   // random expression: opens, letters, closes and operators in legal order,
   // then optional byte corruption
   task automatic queue_expression(input int nest_cap, input int len_cap,
                                   input int open_pct, input int noise_pct);
      byte_q_type text;
      int         nest;
      int         terms;
      bit         want_operand;
      bit         done;
      logic [7:0] ch;
      nest = 0;
      terms = 0;
      want_operand = 1'b1;
      done = 1'b0;
      while (!done) begin
         if (want_operand) begin
            if (nest < nest_cap && $urandom_range(0, 99) < open_pct) begin
               text.push_back(CH_OPEN);
               nest++;
            end else begin
               ch = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
               text.push_back(ch);
               terms++;
               want_operand = 1'b0;
            end
         end else if (nest > 0 && $urandom_range(0, 99) < 30) begin
            text.push_back(CH_CLOSE);
            nest--;
         end else if (terms >= len_cap) begin
            done = 1'b1;
         end else begin
            case ($urandom_range(0, 4))
               0:       ch = CH_ADD;
               1:       ch = CH_SUB;
               2:       ch = CH_MUL;
               3:       ch = CH_DIV;
               default: ch = CH_POW;
            endcase
            text.push_back(ch);
            want_operand = 1'b1;
         end
      end
      while (nest > 0) begin
         text.push_back(CH_CLOSE);
         nest--;
      end
      foreach (text[i])
         if ($urandom_range(0, 99) < noise_pct) text[i] = 8'($urandom);
      queue_expr(text);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (infix_pending.size() > 0 &&
             ((bytes_taken >= 150 && bytes_taken < 250) || $urandom_range(0, 99) >= 10)) begin
            next_byte = infix_pending.pop_front();
            req_in_char     <= next_byte.ch;
            req_end_of_expr <= next_byte.fin;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_taken >= 60) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (words_taken >= 200 && words_taken < 320) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 10);
      end
   end

   // monitor and checker
   always @(posedge clock) begin : monitor
      rsp_word_type got;
      rsp_word_type want;
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            convert_infix_byte(req_in_char, req_end_of_expr);
            bytes_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            words_taken++;
            got = {rsp_out_char, rsp_char_present, rsp_last_of_expr, rsp_fault};
            if (postfix_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word %0d: char %h present %b last %b fault %0d",
                           words_taken, got.out_char, got.char_present,
                           got.last_of_expr, got.fault);
            end else begin
               want = postfix_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"word %0d: expected char %h present %b last %b fault %0d,",
                               " got char %h present %b last %b fault %0d"},
                              words_taken, want.out_char, want.char_present,
                              want.last_of_expr, want.fault, got.out_char,
                              got.char_present, got.last_of_expr, got.fault);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else if (infix_pending.size() > 0 || req_valid || postfix_due.size() > 0)
            stuck_cycles++;
      end
   end

   initial begin : watchdog
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      byte_q_type text;
      int         directed_n;

      // fill to the top, overflow on '^', then one byte pops all 16 entries
      repeat (14) text.push_back(CH_OPEN);
      text.push_back(CH_SUB);
      text.push_back(CH_MUL);
      text.push_back(CH_DIV);
      text.push_back(CH_POW);
      text.push_back(8'hFF);
      queue_expr(text);
      // ')' with nothing open
      text.delete();
      text.push_back(CH_CLOSE);
      queue_expr(text);
      // expression that yields no byte
      text.delete();
      text.push_back(CH_OPEN);
      text.push_back(CH_CLOSE);
      queue_expr(text);
      text.delete();
      text.push_back(8'h41);
      text.push_back(CH_ADD);
      text.push_back(8'h7A);
      text.push_back(8'h00);
      queue_expr(text);
      text.delete();
      text.push_back(8'h61);
      text.push_back(CH_POW);
      text.push_back(8'h5A);
      queue_expr(text);
      directed_n = infix_pending.size();

      while (infix_pending.size() < directed_n + RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       queue_expression(20, 12, 85, 0);
            1, 2:    queue_expression(3, $urandom_range(1, 5), 25, 30);
            default: queue_expression(4, $urandom_range(1, 6), 25, 0);
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (infix_pending.size() != 0 || req_valid) @(posedge clock);
      while (postfix_due.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (mismatches == 0 && postfix_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
